/* design/tcp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the triangle cull and project block.
package tcp_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int SPLIT_W  = 34;
    localparam int LO_W     = SPLIT_W + 1 + DIFF_W;
    localparam int HI_W     = (CROSS_W - SPLIT_W) + DIFF_W;
    localparam int TERM_W   = HI_W + SPLIT_W;
    localparam int DOT_W    = TERM_W + 2;

    localparam int NUM_W    = COORD_W + DIFF_W;
    localparam int MAG_W    = NUM_W + 1;
    localparam int DEN_W    = DIFF_W + 1;
    localparam int DIV_BITS = 34;
    localparam int TOP_W    = MAG_W - DIV_BITS;
    localparam int QS_W     = DIV_BITS + 2;
    localparam int RES_W    = QS_W + 1;

    localparam int LANE_PRE   = 4;
    localparam int PROJ_LAT   = LANE_PRE + DIV_BITS + 1;
    localparam int CULL_LAT   = 6;
    localparam int STATUS_DLY = PROJ_LAT - CULL_LAT;
    localparam int PIPE_DEPTH = PROJ_LAT + 2;

    localparam logic [1:0] ST_DRAWN   = 2'd0;
    localparam logic [1:0] ST_CULLED  = 2'd1;
    localparam logic [1:0] ST_BEHIND  = 2'd2;
    localparam logic [1:0] ST_ONPLANE = 2'd3;

    localparam logic [1:0] CFG_EYE_X  = 2'd0;
    localparam logic [1:0] CFG_EYE_Y  = 2'd1;
    localparam logic [1:0] CFG_EYE_Z  = 2'd2;
    localparam logic [1:0] CFG_CULL   = 2'd3;

    localparam logic [COORD_W-1:0] EYE_Z_RESET = 32'd6553600;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh80000000;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vertex;

    typedef struct packed {
        logic cull;
        logic behind;
        logic onplane;
    } t_cull_flags;

    typedef struct packed {
        logic [1:0] status;
        t_coord     p0_x;
        t_coord     p0_y;
        t_coord     p1_x;
        t_coord     p1_y;
        t_coord     p2_x;
        t_coord     p2_y;
    } t_result;

    function automatic t_diff sub_ext(input t_coord a, input t_coord b);
        t_diff r;
        r = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return r;
    endfunction

endpackage

/* design/triangle_cull_and_project_core.sv */
`timescale 1ns / 1ps
// Top level: triangle back-face cull and perspective projection core.
// The pipeline depth is set by the 34-step divide in each lane.
// Throughput: one triangle per cycle; the whole pipeline holds only while the output stalls.
// Six projection lanes run beside the cull pipeline; the merge stage is the output register.
// Reset (synchronous, active low) empties the pipeline and loads eye (0, 0, 100.0), culling on.
module triangle_cull_and_project_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_v0_x,
    input  logic [31:0] i_v0_y,
    input  logic [31:0] i_v0_z,
    input  logic [31:0] i_v1_x,
    input  logic [31:0] i_v1_y,
    input  logic [31:0] i_v1_z,
    input  logic [31:0] i_v2_x,
    input  logic [31:0] i_v2_y,
    input  logic [31:0] i_v2_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_p0_x,
    output logic [31:0] o_p0_y,
    output logic [31:0] o_p1_x,
    output logic [31:0] o_p1_y,
    output logic [31:0] o_p2_x,
    output logic [31:0] o_p2_y
);

    tcp_pkg::t_vertex r_eye;
    logic r_cull_en;
    logic [tcp_pkg::PIPE_DEPTH-1:0] r_vld;
    tcp_pkg::t_vertex r_v0, r_v1, r_v2;
    logic [1:0] r_sdly [tcp_pkg::STATUS_DLY];
    logic [1:0] cull_status;
    tcp_pkg::t_coord lane_p [6];
    tcp_pkg::t_result res;
    logic en, in_acc;

    assign en         = !r_vld[tcp_pkg::PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready = en;
    assign in_acc     = i_in_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye.x   <= '0;
            r_eye.y   <= '0;
            r_eye.z   <= tcp_pkg::EYE_Z_RESET;
            r_cull_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcp_pkg::CFG_EYE_X: r_eye.x   <= i_cfg_data;
                tcp_pkg::CFG_EYE_Y: r_eye.y   <= i_cfg_data;
                tcp_pkg::CFG_EYE_Z: r_eye.z   <= i_cfg_data;
                tcp_pkg::CFG_CULL:  r_cull_en <= i_cfg_data[0];
                default:            r_cull_en <= r_cull_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[tcp_pkg::PIPE_DEPTH-2:0], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v0 <= {i_v0_x, i_v0_y, i_v0_z};
            r_v1 <= {i_v1_x, i_v1_y, i_v1_z};
            r_v2 <= {i_v2_x, i_v2_y, i_v2_z};
            r_sdly[0] <= cull_status;
            for (int k = 1; k < tcp_pkg::STATUS_DLY; k++) begin
                r_sdly[k] <= r_sdly[k-1];
            end
        end
    end

    tcp_cull u_cull (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_v0      (r_v0),
        .i_v1      (r_v1),
        .i_v2      (r_v2),
        .i_eye     (r_eye),
        .i_cull_en (r_cull_en),
        .o_status  (cull_status)
    );

    tcp_proj_lane u_lane0x (.i_clk(i_clk), .i_en(en), .i_c(r_v0.x), .i_e(r_eye.x),
                            .i_z(r_v0.z), .i_ez(r_eye.z), .o_p(lane_p[0]));
    tcp_proj_lane u_lane0y (.i_clk(i_clk), .i_en(en), .i_c(r_v0.y), .i_e(r_eye.y),
                            .i_z(r_v0.z), .i_ez(r_eye.z), .o_p(lane_p[1]));
    tcp_proj_lane u_lane1x (.i_clk(i_clk), .i_en(en), .i_c(r_v1.x), .i_e(r_eye.x),
                            .i_z(r_v1.z), .i_ez(r_eye.z), .o_p(lane_p[2]));
    tcp_proj_lane u_lane1y (.i_clk(i_clk), .i_en(en), .i_c(r_v1.y), .i_e(r_eye.y),
                            .i_z(r_v1.z), .i_ez(r_eye.z), .o_p(lane_p[3]));
    tcp_proj_lane u_lane2x (.i_clk(i_clk), .i_en(en), .i_c(r_v2.x), .i_e(r_eye.x),
                            .i_z(r_v2.z), .i_ez(r_eye.z), .o_p(lane_p[4]));
    tcp_proj_lane u_lane2y (.i_clk(i_clk), .i_en(en), .i_c(r_v2.y), .i_e(r_eye.y),
                            .i_z(r_v2.z), .i_ez(r_eye.z), .o_p(lane_p[5]));

    tcp_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_status (r_sdly[tcp_pkg::STATUS_DLY-1]),
        .i_p      (lane_p),
        .o_res    (res)
    );

    assign o_out_valid = r_vld[tcp_pkg::PIPE_DEPTH-1];
    assign o_status    = res.status;
    assign o_p0_x      = res.p0_x;
    assign o_p0_y      = res.p0_y;
    assign o_p1_x      = res.p1_x;
    assign o_p1_y      = res.p1_y;
    assign o_p2_x      = res.p2_x;
    assign o_p2_y      = res.p2_y;

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != tcp_pkg::ST_DRAWN) |->
        (o_p0_x == '0 && o_p0_y == '0 && o_p1_x == '0 &&
         o_p1_y == '0 && o_p2_x == '0 && o_p2_y == '0))
        else $error("rejected triangle carries nonzero coordinates");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status) &&
        $stable(o_p0_x) && $stable(o_p2_y)))
        else $error("stalled result changed");

    a_enter_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted transaction not in first stage");
`endif

endmodule

/* design/tcp_cull.sv */
`timescale 1ns / 1ps
// Back-face test pipeline with eye-plane checks, giving the triangle status.
module tcp_cull (
    input  logic              i_clk,
    input  logic              i_en,
    input  tcp_pkg::t_vertex  i_v0,
    input  tcp_pkg::t_vertex  i_v1,
    input  tcp_pkg::t_vertex  i_v2,
    input  tcp_pkg::t_vertex  i_eye,
    input  logic              i_cull_en,
    output logic [1:0]        o_status
);

    tcp_pkg::t_diff r1_a [3];
    tcp_pkg::t_diff r1_b [3];
    tcp_pkg::t_diff r1_d [3];
    tcp_pkg::t_diff r2_d [3];
    tcp_pkg::t_diff r3_d [3];
    logic signed [tcp_pkg::PROD_W-1:0]  r2_p [6];
    logic signed [tcp_pkg::CROSS_W-1:0] r3_cr [3];
    logic signed [tcp_pkg::LO_W-1:0]    r4_lo [3];
    logic signed [tcp_pkg::HI_W-1:0]    r4_hi [3];
    logic signed [tcp_pkg::TERM_W-1:0]  r5_t [3];
    tcp_pkg::t_cull_flags r1_f, r2_f, r3_f, r4_f, r5_f, n_f;
    logic signed [tcp_pkg::DOT_W-1:0] n_dot;
    logic [1:0] r_status;

    always_comb begin
        n_f.cull    = i_cull_en;
        n_f.behind  = ($signed(i_v0.z) > $signed(i_eye.z)) ||
                      ($signed(i_v1.z) > $signed(i_eye.z)) ||
                      ($signed(i_v2.z) > $signed(i_eye.z));
        n_f.onplane = (i_v0.z == i_eye.z) || (i_v1.z == i_eye.z) || (i_v2.z == i_eye.z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a[0] <= tcp_pkg::sub_ext(i_v1.x, i_v0.x);
            r1_a[1] <= tcp_pkg::sub_ext(i_v1.y, i_v0.y);
            r1_a[2] <= tcp_pkg::sub_ext(i_v1.z, i_v0.z);
            r1_b[0] <= tcp_pkg::sub_ext(i_v2.x, i_v1.x);
            r1_b[1] <= tcp_pkg::sub_ext(i_v2.y, i_v1.y);
            r1_b[2] <= tcp_pkg::sub_ext(i_v2.z, i_v1.z);
            r1_d[0] <= tcp_pkg::sub_ext(i_v0.x, i_eye.x);
            r1_d[1] <= tcp_pkg::sub_ext(i_v0.y, i_eye.y);
            r1_d[2] <= tcp_pkg::sub_ext(i_v0.z, i_eye.z);
            r1_f    <= n_f;

            r2_p[0] <= r1_a[1] * r1_b[2];
            r2_p[1] <= r1_a[2] * r1_b[1];
            r2_p[2] <= r1_a[2] * r1_b[0];
            r2_p[3] <= r1_a[0] * r1_b[2];
            r2_p[4] <= r1_a[0] * r1_b[1];
            r2_p[5] <= r1_a[1] * r1_b[0];
            r2_d    <= r1_d;
            r2_f    <= r1_f;

            r3_cr[0] <= r2_p[0] - r2_p[1];
            r3_cr[1] <= r2_p[2] - r2_p[3];
            r3_cr[2] <= r2_p[4] - r2_p[5];
            r3_d     <= r2_d;
            r3_f     <= r2_f;

            for (int k = 0; k < 3; k++) begin
                r4_lo[k] <= $signed({1'b0, r3_cr[k][tcp_pkg::SPLIT_W-1:0]}) * r3_d[k];
                r4_hi[k] <= $signed(r3_cr[k][tcp_pkg::CROSS_W-1:tcp_pkg::SPLIT_W]) * r3_d[k];
            end
            r4_f <= r3_f;

            for (int k = 0; k < 3; k++) begin
                r5_t[k] <= $signed({r4_hi[k], {tcp_pkg::SPLIT_W{1'b0}}}) + r4_lo[k];
            end
            r5_f <= r4_f;

            if (r5_f.cull && !n_dot[tcp_pkg::DOT_W-1]) begin
                r_status <= tcp_pkg::ST_CULLED;
            end else if (r5_f.behind) begin
                r_status <= tcp_pkg::ST_BEHIND;
            end else if (r5_f.onplane) begin
                r_status <= tcp_pkg::ST_ONPLANE;
            end else begin
                r_status <= tcp_pkg::ST_DRAWN;
            end
        end
    end

    assign n_dot    = r5_t[0] + r5_t[1] + r5_t[2];
    assign o_status = r_status;

endmodule

/* design/tcp_proj_lane.sv */
`timescale 1ns / 1ps
// One projection lane: multiply, pipelined restoring divide, round and saturate.
module tcp_proj_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  tcp_pkg::t_coord i_c,
    input  tcp_pkg::t_coord i_e,
    input  tcp_pkg::t_coord i_z,
    input  tcp_pkg::t_coord i_ez,
    output tcp_pkg::t_coord o_p
);

    localparam int NB = tcp_pkg::DIV_BITS;

    tcp_pkg::t_diff n_dz;
    logic [tcp_pkg::DIFF_W-1:0] n_dmag;
    tcp_pkg::t_diff r1_diff;
    logic [tcp_pkg::DIFF_W-1:0] r1_dmag, r2_dmag;
    logic r1_dzneg, r2_dzneg;
    tcp_pkg::t_coord r1_e, r2_e, r3_e;
    logic signed [tcp_pkg::NUM_W-1:0] r2_num;
    logic [tcp_pkg::NUM_W-1:0] n_nummag;
    logic [tcp_pkg::MAG_W-1:0] r3_mag;
    logic [tcp_pkg::DEN_W-1:0] r3_den;
    logic r3_neg;

    logic [tcp_pkg::DEN_W-1:0] r_rem [0:NB];
    logic [NB-1:0]             r_low [0:NB];
    logic [NB-1:0]             r_q   [0:NB];
    logic [tcp_pkg::DEN_W-1:0] r_den [0:NB];
    logic                      r_neg [0:NB];
    logic                      r_ovf [0:NB];
    tcp_pkg::t_coord           r_e   [0:NB];

    logic [tcp_pkg::TOP_W-1:0] n_top;
    logic signed [tcp_pkg::QS_W-1:0]  n_qs;
    logic signed [tcp_pkg::RES_W-1:0] n_res;
    tcp_pkg::t_coord n_p, r_p;

    always_comb begin
        n_dz   = tcp_pkg::sub_ext(i_z, i_ez);
        n_dmag = n_dz[tcp_pkg::DIFF_W-1] ? tcp_pkg::DIFF_W'(-n_dz) : tcp_pkg::DIFF_W'(n_dz);
        n_nummag = r2_num[tcp_pkg::NUM_W-1] ? tcp_pkg::NUM_W'(-r2_num)
                                              : tcp_pkg::NUM_W'(r2_num);
        n_top  = r3_mag[tcp_pkg::MAG_W-1:NB];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_diff  <= tcp_pkg::sub_ext(i_c, i_e);
            r1_dmag  <= n_dmag;
            r1_dzneg <= n_dz[tcp_pkg::DIFF_W-1];
            r1_e     <= i_e;

            r2_num   <= i_ez * r1_diff;
            r2_dmag  <= r1_dmag;
            r2_dzneg <= r1_dzneg;
            r2_e     <= r1_e;

            r3_mag <= tcp_pkg::MAG_W'({n_nummag, 1'b0}) + tcp_pkg::MAG_W'(r2_dmag);
            r3_den <= {r2_dmag, 1'b0};
            r3_neg <= r2_num[tcp_pkg::NUM_W-1] ^ r2_dzneg;
            r3_e   <= r2_e;

            r_rem[0] <= tcp_pkg::DEN_W'(n_top);
            r_low[0] <= r3_mag[NB-1:0];
            r_q[0]   <= '0;
            r_den[0] <= r3_den;
            r_neg[0] <= r3_neg;
            r_ovf[0] <= tcp_pkg::DEN_W'(n_top) >= r3_den;
            r_e[0]   <= r3_e;
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_div
        logic [tcp_pkg::DEN_W:0] n_sh;
        logic n_ge;
        assign n_sh = {r_rem[k], r_low[k][NB-1]};
        assign n_ge = n_sh >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? tcp_pkg::DEN_W'(n_sh - {1'b0, r_den[k]})
                                   : n_sh[tcp_pkg::DEN_W-1:0];
                r_low[k+1] <= {r_low[k][NB-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][NB-2:0], n_ge};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_e[k+1]   <= r_e[k];
            end
        end
    end

    always_comb begin
        n_qs  = r_neg[NB] ? -$signed({2'b00, r_q[NB]}) : $signed({2'b00, r_q[NB]});
        n_res = r_e[NB] - n_qs;
        if (r_ovf[NB]) begin
            n_p = r_neg[NB] ? tcp_pkg::SAT_MAX : tcp_pkg::SAT_MIN;
        end else if (n_res > tcp_pkg::RES_W'(tcp_pkg::SAT_MAX)) begin
            n_p = tcp_pkg::SAT_MAX;
        end else if (n_res < tcp_pkg::RES_W'(tcp_pkg::SAT_MIN)) begin
            n_p = tcp_pkg::SAT_MIN;
        end else begin
            n_p = n_res[tcp_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* design/tcp_merge.sv */
`timescale 1ns / 1ps
// Output stage: joins the status with the six lane results, zeroing on reject.
module tcp_merge (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [1:0]       i_status,
    input  tcp_pkg::t_coord  i_p [6],
    output tcp_pkg::t_result o_res
);

    tcp_pkg::t_result n_res, r_res;
    logic n_draw;

    always_comb begin
        n_draw       = (i_status == tcp_pkg::ST_DRAWN);
        n_res.status = i_status;
        n_res.p0_x   = n_draw ? i_p[0] : '0;
        n_res.p0_y   = n_draw ? i_p[1] : '0;
        n_res.p1_x   = n_draw ? i_p[2] : '0;
        n_res.p1_y   = n_draw ? i_p[3] : '0;
        n_res.p2_x   = n_draw ? i_p[4] : '0;
        n_res.p2_y   = n_draw ? i_p[5] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
